// ===== src/gsps_pkg.sv =====
// Gas sensor poll sequencer: shared types, constants and the CRC-8 helper.
// Used by gsps_core, gas_sensor_poll_sequencer and the testbench; no dependencies.
package gsps_pkg;

    // Timing, in one-millisecond ticks
    localparam logic [15:0] CYCLE_TICKS = 16'd30000;
    localparam logic [15:0] RETRY_TICKS = 16'd500;
    localparam logic [15:0] STEP_DELAY  = 16'd30;
    localparam logic [15:0] READ_DELAY  = 16'd150;

    // Sensor command words
    localparam logic [15:0] CMD_FEAT_QUERY = 16'h202F;
    localparam logic [15:0] CMD_INIT       = 16'h20AE;
    localparam logic [15:0] CMD_HUMIDITY   = 16'h2061;
    localparam logic [15:0] CMD_MEASURE    = 16'h2008;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] ID_BYTE0 = 8'h10;
    localparam logic [7:0] ID_BYTE1 = 8'h06;

    // Configuration register indexes
    localparam int unsigned REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_HUMIDITY = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_DEV_ADDR = 1'b1;
    localparam logic [6:0] DEV_ADDR_RESET = 7'd88;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_WR_DONE = 2'd1,
        OP_RD_DONE = 2'd2
    } op_t;

    typedef enum logic [5:0] {
        PH_FEAT_Q  = 6'b000001,
        PH_FEAT_RD = 6'b000010,
        PH_INIT    = 6'b000100,
        PH_HUM     = 6'b001000,
        PH_MEAS    = 6'b010000,
        PH_TVOC_RD = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic       ack;
        logic [7:0] rd_byte0;
        logic [7:0] rd_byte1;
        logic [7:0] rd_byte2;
    } item_t;

    typedef struct packed {
        logic        cmd_valid;
        logic        cmd_is_read;
        logic [15:0] cmd_code;
        logic        cmd_has_arg;
        logic [15:0] cmd_arg;
        logic [7:0]  cmd_arg_crc;
        logic [15:0] tvoc_ppb;
        logic        tvoc_valid;
        logic        error_seen;
    } result_t;

    typedef struct packed {
        phase_t phase;
        logic   awaiting;
    } status_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== src/gsps_core.sv =====
// Sequencer state and per-item next-state/result logic.
// Depends on gsps_pkg.
module gsps_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  gsps_pkg::item_t   item,
    input  logic [15:0]       humidity_comp,
    output gsps_pkg::result_t result,
    output gsps_pkg::status_t status
);

    gsps_pkg::phase_t phase_reg, phase_next;
    logic        await_reg, await_next;
    logic [15:0] wait_reg, wait_next;
    logic [15:0] since_reg, since_next;
    logic [15:0] tvoc_reg, tvoc_next;
    logic        valid_reg, valid_next;
    logic        error_reg, error_next;

    logic        err;
    logic [7:0]  hum_crc;
    logic [7:0]  rd_crc;
    logic [15:0] cycle_wait;
    logic        wr_phase;
    logic        rd_phase;

    assign hum_crc = gsps_pkg::crc8_byte(
        gsps_pkg::crc8_byte(gsps_pkg::CRC_INIT, humidity_comp[15:8]), humidity_comp[7:0]);
    assign rd_crc = gsps_pkg::crc8_byte(gsps_pkg::crc8_byte(
        gsps_pkg::crc8_byte(gsps_pkg::CRC_INIT, item.rd_byte0), item.rd_byte1), item.rd_byte2);

    // remaining part of the poll period, zero once it has run out
    assign cycle_wait = (since_reg < gsps_pkg::CYCLE_TICKS) ?
                        (gsps_pkg::CYCLE_TICKS - since_reg) : 16'd0;

    assign wr_phase = (phase_reg == gsps_pkg::PH_FEAT_Q) || (phase_reg == gsps_pkg::PH_INIT) ||
                      (phase_reg == gsps_pkg::PH_HUM) || (phase_reg == gsps_pkg::PH_MEAS);
    assign rd_phase = (phase_reg == gsps_pkg::PH_FEAT_RD) ||
                      (phase_reg == gsps_pkg::PH_TVOC_RD);

    always_comb
    begin
        phase_next = phase_reg;
        await_next = await_reg;
        wait_next  = wait_reg;
        since_next = since_reg;
        tvoc_next  = tvoc_reg;
        valid_next = valid_reg;
        error_next = error_reg;
        err        = 1'b0;
        result     = '0;

        case (item.op)
            gsps_pkg::OP_TICK:
            begin
                if (since_reg != 16'hFFFF)
                    since_next = since_reg + 16'd1;
                if (!await_reg)
                begin
                    if (wait_reg > 16'd1)
                        wait_next = wait_reg - 16'd1;
                    else
                    begin
                        wait_next = 16'd0;
                        await_next = 1'b1;
                        result.cmd_valid = 1'b1;
                        case (phase_reg)
                            gsps_pkg::PH_FEAT_Q:  result.cmd_code = gsps_pkg::CMD_FEAT_QUERY;
                            gsps_pkg::PH_FEAT_RD: result.cmd_is_read = 1'b1;
                            gsps_pkg::PH_INIT:    result.cmd_code = gsps_pkg::CMD_INIT;
                            gsps_pkg::PH_HUM:
                            begin
                                result.cmd_code    = gsps_pkg::CMD_HUMIDITY;
                                result.cmd_has_arg = 1'b1;
                                result.cmd_arg     = humidity_comp;
                                result.cmd_arg_crc = hum_crc;
                                since_next         = 16'd0;
                            end
                            gsps_pkg::PH_MEAS:    result.cmd_code = gsps_pkg::CMD_MEASURE;
                            gsps_pkg::PH_TVOC_RD: result.cmd_is_read = 1'b1;
                            default:
                            begin
                                result.cmd_valid = 1'b0;
                                await_next = 1'b0;
                                err = 1'b1;
                            end
                        endcase
                    end
                end
            end
            gsps_pkg::OP_WR_DONE:
            begin
                if (await_reg && wr_phase)
                begin
                    await_next = 1'b0;
                    wait_next  = gsps_pkg::STEP_DELAY;
                    if (!item.ack)
                        err = 1'b1;
                    else
                    begin
                        case (phase_reg)
                            gsps_pkg::PH_FEAT_Q: phase_next = gsps_pkg::PH_FEAT_RD;
                            gsps_pkg::PH_INIT:   phase_next = gsps_pkg::PH_HUM;
                            gsps_pkg::PH_HUM:    phase_next = gsps_pkg::PH_MEAS;
                            default:
                            begin
                                phase_next = gsps_pkg::PH_TVOC_RD;
                                wait_next  = gsps_pkg::READ_DELAY;
                            end
                        endcase
                    end
                end
            end
            gsps_pkg::OP_RD_DONE:
            begin
                if (await_reg && rd_phase)
                begin
                    await_next = 1'b0;
                    if (!item.ack || rd_crc != 8'd0)
                        err = 1'b1;
                    else if (phase_reg == gsps_pkg::PH_FEAT_RD)
                    begin
                        if (item.rd_byte0 != gsps_pkg::ID_BYTE0 ||
                            item.rd_byte1 != gsps_pkg::ID_BYTE1)
                            err = 1'b1;
                        else
                        begin
                            phase_next = gsps_pkg::PH_INIT;
                            wait_next  = gsps_pkg::STEP_DELAY;
                        end
                    end
                    else
                    begin
                        tvoc_next  = {item.rd_byte0, item.rd_byte1};
                        valid_next = 1'b1;
                        phase_next = gsps_pkg::PH_HUM;
                        wait_next  = cycle_wait;
                    end
                end
            end
            default: ;
        endcase

        if (err)
        begin
            error_next = 1'b1;
            valid_next = 1'b0;
            phase_next = gsps_pkg::PH_FEAT_Q;
            await_next = 1'b0;
            wait_next  = gsps_pkg::RETRY_TICKS;
        end

        result.tvoc_ppb   = tvoc_next;
        result.tvoc_valid = valid_next;
        result.error_seen = error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= gsps_pkg::PH_FEAT_Q;
            await_reg <= 1'b0;
            wait_reg  <= gsps_pkg::STEP_DELAY;
            since_reg <= 16'd0;
            tvoc_reg  <= 16'd0;
            valid_reg <= 1'b0;
            error_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            await_reg <= await_next;
            wait_reg  <= wait_next;
            since_reg <= since_next;
            tvoc_reg  <= tvoc_next;
            valid_reg <= valid_next;
            error_reg <= error_next;
        end
    end

    assign status.phase    = phase_reg;
    assign status.awaiting = await_reg;

endmodule

// ===== src/gas_sensor_poll_sequencer.sv =====
// Gas sensor poll sequencer top level: item register, result register, config registers.
// Depends on gsps_pkg and gsps_core.
//
// Path: an item transfer is captured in the item register, and its result then passes
// to the result register. Throughput: one item per cycle; the item register stalls
// only while the result register holds a result that the far side is stalling.
// Reset: asynchronous, active low; sequencer starts at the feature query with a
// 30-tick wait, humidity word 0, device address 88.
module gas_sensor_poll_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  gsps_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output gsps_pkg::result_t                 result,
    input  logic                              wr_en,
    input  logic [gsps_pkg::REG_IDX_W-1:0]    wr_index,
    input  logic [15:0]                       wr_data
);

    logic              in_vld_reg;
    gsps_pkg::item_t   in_reg;
    logic              out_vld_reg;
    gsps_pkg::result_t out_reg;
    logic [15:0]       humidity_reg;
    logic [6:0]        dev_addr_reg;   // held for the external master only

    logic              out_free;
    logic              fire;
    gsps_pkg::result_t core_result;
    gsps_pkg::status_t core_status;

    assign out_free   = !out_vld_reg || !result_stall;
    assign fire       = in_vld_reg && out_free;
    assign item_stall = in_vld_reg && !out_free;

    gsps_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .item          (in_reg),
        .humidity_comp (humidity_reg),
        .result        (core_result),
        .status        (core_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
                in_vld_reg <= item_valid;
            if (out_free)
                out_vld_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_reg <= item;
        if (fire)
            out_reg <= core_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            humidity_reg <= 16'd0;
            dev_addr_reg <= gsps_pkg::DEV_ADDR_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                gsps_pkg::REG_HUMIDITY: humidity_reg <= wr_data;
                gsps_pkg::REG_DEV_ADDR: dev_addr_reg <= wr_data[6:0];
                default: ;
            endcase
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    // stall is only raised with both stages full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (in_vld_reg && out_vld_reg))
        else $error("item stall without both stages full");

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(core_status.phase))
        else $error("phase register not one-hot");

    // read requests never carry a command word or argument
    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.cmd_is_read) |->
            (result.cmd_valid && result.cmd_code == 16'd0 && !result.cmd_has_arg))
        else $error("malformed read request");

    // an issued command puts the sequencer into the awaiting state
    a_cmd_sets_await: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && core_result.cmd_valid) |=> core_status.awaiting)
        else $error("command issued without awaiting completion");

    a_dev_addr_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_index == gsps_pkg::REG_DEV_ADDR) |=> dev_addr_reg == $past(wr_data[6:0]))
        else $error("device address write lost");

endmodule

// ===== sim/tb_gas_sensor_poll_sequencer.sv =====
// Self-checking testbench for gas_sensor_poll_sequencer: a command predictor in a small
// scoreboard class, random valid/stall traffic on both channels, register writes when idle.
// Depends on gsps_pkg and the sequencer RTL only.
module tb_gas_sensor_poll_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    // random traffic runs up to this many transfers, then one good poll finishes the run
    localparam int unsigned RANDOM_UNTIL  = 900;
    localparam int unsigned SETTING_EVERY = 300;
    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned REPORT_CAP    = 100;

    // Predicts the command and status word for each item transfer and checks the results
    class sequencer_board;
        gsps_pkg::phase_t  phase;
        bit                awaiting;
        logic [15:0]       wait_left;
        logic [15:0]       since_start;
        logic [15:0]       tvoc;
        logic [15:0]       humidity;
        logic [6:0]        dev_addr;
        bit                valid_flag;
        bit                error_flag;
        gsps_pkg::result_t expected_cmds[$];
        int unsigned       mismatches;
        int unsigned       commands;
        int unsigned       good_readings;
        int unsigned       retries;

        function new();
            phase         = gsps_pkg::PH_FEAT_Q;
            awaiting      = 1'b0;
            wait_left     = gsps_pkg::STEP_DELAY;
            since_start   = '0;
            tvoc          = '0;
            humidity      = '0;
            dev_addr      = gsps_pkg::DEV_ADDR_RESET;
            valid_flag    = 1'b0;
            error_flag    = 1'b0;
            mismatches    = 0;
            commands      = 0;
            good_readings = 0;
            retries       = 0;
        endfunction

        // Bit-serial CRC-8, MSB first, over the low nbytes of data
        static function logic [7:0] crc8(input logic [23:0] data, input int nbytes);
            logic [7:0] c;
            logic       fb;
            c = gsps_pkg::CRC_INIT;
            for (int i = 8 * nbytes - 1; i >= 0; i--)
            begin
                fb = c[7] ^ data[i];
                c  = {c[6:0], 1'b0} ^ (fb ? gsps_pkg::CRC_POLY : 8'h00);
            end
            return c;
        endfunction

        function bit reads_next();
            return phase == gsps_pkg::PH_FEAT_RD || phase == gsps_pkg::PH_TVOC_RD;
        endfunction

        function int unsigned pending();
            return expected_cmds.size();
        endfunction

        function void set_register(input logic [gsps_pkg::REG_IDX_W-1:0] idx,
                                   input logic [15:0] data);
            if (idx == gsps_pkg::REG_HUMIDITY)
                humidity = data;
            else
                dev_addr = data[6:0];
        endfunction

        function void retry();
            error_flag = 1'b1;
            valid_flag = 1'b0;
            phase      = gsps_pkg::PH_FEAT_Q;
            awaiting   = 1'b0;
            wait_left  = gsps_pkg::RETRY_TICKS;
            retries++;
        endfunction

        function void step_to(input gsps_pkg::phase_t next, input logic [15:0] ticks);
            phase     = next;
            awaiting  = 1'b0;
            wait_left = ticks;
        endfunction

        function void predict_command(input gsps_pkg::item_t it);
            gsps_pkg::result_t cmd;
            logic [15:0]       cycle_wait;
            cmd = '0;
            case (it.op)
                gsps_pkg::OP_TICK:
                begin
                    if (since_start != 16'hFFFF)
                        since_start++;
                    if (!awaiting && wait_left > 16'd1)
                        wait_left--;
                    else if (!awaiting)
                    begin
                        wait_left     = '0;
                        cmd.cmd_valid = 1'b1;
                        case (phase)
                            gsps_pkg::PH_FEAT_Q:  cmd.cmd_code    = gsps_pkg::CMD_FEAT_QUERY;
                            gsps_pkg::PH_INIT:    cmd.cmd_code    = gsps_pkg::CMD_INIT;
                            gsps_pkg::PH_MEAS:    cmd.cmd_code    = gsps_pkg::CMD_MEASURE;
                            gsps_pkg::PH_FEAT_RD: cmd.cmd_is_read = 1'b1;
                            gsps_pkg::PH_TVOC_RD: cmd.cmd_is_read = 1'b1;
                            gsps_pkg::PH_HUM:
                            begin
                                cmd.cmd_code    = gsps_pkg::CMD_HUMIDITY;
                                cmd.cmd_has_arg = 1'b1;
                                cmd.cmd_arg     = humidity;
                                cmd.cmd_arg_crc = crc8({8'h00, humidity}, 2);
                                since_start     = '0;
                            end
                            default:
                            begin
                                cmd.cmd_valid = 1'b0;
                                retry();
                            end
                        endcase
                        awaiting = cmd.cmd_valid;
                        if (cmd.cmd_valid)
                            commands++;
                    end
                end
                gsps_pkg::OP_WR_DONE:
                    if (awaiting && !reads_next())
                    begin
                        if (!it.ack)
                            retry();
                        else
                            case (phase)
                                gsps_pkg::PH_FEAT_Q:
                                    step_to(gsps_pkg::PH_FEAT_RD, gsps_pkg::STEP_DELAY);
                                gsps_pkg::PH_INIT:
                                    step_to(gsps_pkg::PH_HUM, gsps_pkg::STEP_DELAY);
                                gsps_pkg::PH_HUM:
                                    step_to(gsps_pkg::PH_MEAS, gsps_pkg::STEP_DELAY);
                                default:
                                    step_to(gsps_pkg::PH_TVOC_RD, gsps_pkg::READ_DELAY);
                            endcase
                    end
                gsps_pkg::OP_RD_DONE:
                    if (awaiting && reads_next())
                    begin
                        if (!it.ack ||
                            crc8({it.rd_byte0, it.rd_byte1, it.rd_byte2}, 3) != 8'h00)
                            retry();
                        else if (phase == gsps_pkg::PH_FEAT_RD)
                        begin
                            if (it.rd_byte0 != gsps_pkg::ID_BYTE0 ||
                                it.rd_byte1 != gsps_pkg::ID_BYTE1)
                                retry();
                            else
                                step_to(gsps_pkg::PH_INIT, gsps_pkg::STEP_DELAY);
                        end
                        else
                        begin
                            tvoc       = {it.rd_byte0, it.rd_byte1};
                            valid_flag = 1'b1;
                            good_readings++;
                            // cycle already overdue: request on the next tick
                            cycle_wait = (since_start < gsps_pkg::CYCLE_TICKS) ?
                                         gsps_pkg::CYCLE_TICKS - since_start : 16'd0;
                            step_to(gsps_pkg::PH_HUM, cycle_wait);
                        end
                    end
                default: ;
            endcase
            cmd.tvoc_ppb   = tvoc;
            cmd.tvoc_valid = valid_flag;
            cmd.error_seen = error_flag;
            expected_cmds.push_back(cmd);
        endfunction

        function void compare_field(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(input gsps_pkg::result_t got);
            gsps_pkg::result_t want;
            if (expected_cmds.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result with nothing expected, actual %h", $time, got);
                return;
            end
            want = expected_cmds.pop_front();
            compare_field("cmd_valid",   want.cmd_valid,   got.cmd_valid);
            compare_field("cmd_is_read", want.cmd_is_read, got.cmd_is_read);
            compare_field("cmd_code",    want.cmd_code,    got.cmd_code);
            compare_field("cmd_has_arg", want.cmd_has_arg, got.cmd_has_arg);
            compare_field("cmd_arg",     want.cmd_arg,     got.cmd_arg);
            compare_field("cmd_arg_crc", want.cmd_arg_crc, got.cmd_arg_crc);
            compare_field("tvoc_ppb",    want.tvoc_ppb,    got.tvoc_ppb);
            compare_field("tvoc_valid",  want.tvoc_valid,  got.tvoc_valid);
            compare_field("error_seen",  want.error_seen,  got.error_seen);
        endfunction
    endclass

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           item_valid   = 1'b0;
    logic                           item_stall;
    gsps_pkg::item_t                item         = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    gsps_pkg::result_t              result;
    logic                           wr_en        = 1'b0;
    logic [gsps_pkg::REG_IDX_W-1:0] wr_index     = '0;
    logic [15:0]                    wr_data      = '0;

    sequencer_board board;
    bit             idle_on = 1'b1;
    int             hold_left = 0;
    int unsigned    items_sent = 0;
    int unsigned    regs_written = 0;
    int unsigned    cycle_count;

    gas_sensor_poll_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always #2 clk = ~clk;

    // Result side: stall in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left = 0;
        end
        else if (hold_left != 0)
            hold_left--;
        else if (idle_on && $urandom_range(0, 15) == 0)
        begin
            result_stall <= 1'b1;
            hold_left = $urandom_range(0, 9);
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            board.check_result(result);

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic gsps_pkg::item_t make_item(input logic [1:0] op, input logic ack,
                                                  input logic [7:0] b0, input logic [7:0] b1,
                                                  input logic [7:0] b2);
        gsps_pkg::item_t it;
        it.op       = op;
        it.ack      = ack;
        it.rd_byte0 = b0;
        it.rd_byte1 = b1;
        it.rd_byte2 = b2;
        return it;
    endfunction

    function automatic gsps_pkg::item_t read_item(input logic ack, input logic [7:0] b0,
                                                  input logic [7:0] b1);
        return make_item(gsps_pkg::OP_RD_DONE, ack, b0, b1,
                         sequencer_board::crc8({8'h00, b0, b1}, 2));
    endfunction

    function automatic gsps_pkg::item_t write_item(input logic ack);
        return make_item(gsps_pkg::OP_WR_DONE, ack, 8'($urandom), 8'($urandom),
                         8'($urandom));
    endfunction

    // One item transfer, with an occasional gap before it
    task automatic send(input gsps_pkg::item_t it);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        board.predict_command(it);
        items_sent++;
    endtask

    task automatic tick();
        send(make_item(gsps_pkg::OP_TICK, 1'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom)));
    endtask

    task automatic tick_to_request();
        while (!board.awaiting)
            tick();
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [gsps_pkg::REG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        drain_results();
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        board.set_register(idx, data);
        regs_written++;
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_sequence();
        // unused op code, then completions while nothing is awaited
        send(make_item(2'b11, 1'b1, 8'hFF, 8'hFF, 8'hFF));
        send(make_item(gsps_pkg::OP_WR_DONE, 1'b1, 8'h00, 8'h00, 8'h00));
        send(read_item(1'b1, gsps_pkg::ID_BYTE0, gsps_pkg::ID_BYTE1));
        tick_to_request();
        // tick while the query write is outstanding, then a read completion of the wrong kind
        send(make_item(gsps_pkg::OP_TICK, 1'b0, 8'hFF, 8'h00, 8'hFF));
        send(read_item(1'b1, gsps_pkg::ID_BYTE0, gsps_pkg::ID_BYTE1));
        send(write_item(1'b1));
        // feature read with a good CRC but the wrong ID
        tick_to_request();
        send(read_item(1'b1, gsps_pkg::ID_BYTE0, 8'h07));
    endtask

    // Mostly well-formed progress with random content; some stray and broken transfers
    task automatic random_transfer();
        gsps_pkg::item_t it;
        logic [7:0]      b0;
        logic [7:0]      b1;
        int unsigned     pick;
        it   = make_item(gsps_pkg::OP_TICK, 1'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
        pick = $urandom_range(0, 15);
        if (!board.awaiting)
        begin
            if (pick == 0)
                it.op = 2'($urandom_range(0, 3));
        end
        else if (pick == 5)
            it.op = 2'($urandom_range(0, 3));
        else if (pick > 5)
        begin
            it.ack = $urandom_range(0, 15) != 0;
            if (!board.reads_next())
                it.op = gsps_pkg::OP_WR_DONE;
            else
            begin
                b0 = 8'($urandom);
                b1 = 8'($urandom);
                if (board.phase == gsps_pkg::PH_FEAT_RD && $urandom_range(0, 5) != 0)
                begin
                    b0 = gsps_pkg::ID_BYTE0;
                    b1 = gsps_pkg::ID_BYTE1;
                end
                it = read_item(it.ack, b0, b1);
                // TVOC reads here always fail, since a good one starts a full cycle wait
                if (board.phase == gsps_pkg::PH_TVOC_RD || $urandom_range(0, 7) == 0)
                    it.rd_byte2 = it.rd_byte2 ^ 8'($urandom_range(1, 255));
            end
        end
        send(it);
    endtask

    // Clean progress from wherever the sequencer is to a good TVOC reading
    task automatic good_poll();
        while (!(board.awaiting && board.phase == gsps_pkg::PH_TVOC_RD))
        begin
            if (!board.awaiting)
                tick();
            else if (board.phase == gsps_pkg::PH_FEAT_RD)
                send(read_item(1'b1, gsps_pkg::ID_BYTE0, gsps_pkg::ID_BYTE1));
            else
                send(write_item(1'b1));
        end
        send(read_item(1'b1, 8'($urandom), 8'($urandom)));
        repeat (20) tick();
    endtask

    initial
    begin
        int unsigned next_setting;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(gsps_pkg::REG_HUMIDITY, 16'hFFFF);
        write_reg(gsps_pkg::REG_DEV_ADDR, 16'd127);
        directed_sequence();
        write_reg(gsps_pkg::REG_HUMIDITY, 16'h0000);
        write_reg(gsps_pkg::REG_DEV_ADDR, 16'h0000);

        next_setting = items_sent + SETTING_EVERY;
        while (items_sent < RANDOM_UNTIL)
        begin
            if (items_sent % 256 == 0)
                idle_on = $urandom_range(0, 3) != 0;
            random_transfer();
            if (items_sent >= next_setting)
            begin
                write_reg(gsps_pkg::REG_HUMIDITY, 16'($urandom));
                write_reg(gsps_pkg::REG_DEV_ADDR, 16'($urandom));
                next_setting += SETTING_EVERY;
            end
        end

        idle_on = 1'b0;
        write_reg(gsps_pkg::REG_HUMIDITY, 16'($urandom));
        good_poll();
        drain_results();
        repeat (8) @(posedge clk);

        $display("Covered %0d item transfers: %0d commands, %0d good TVOC reads, %0d retries,",
                 items_sent, board.commands, board.good_readings, board.retries);
        $display("%0d register writes, %0d mismatches.", regs_written, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
